// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds every cycle outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("assertion failed");
// implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("assertion failed");
`endif

// ===== hw/rtl/hrke_pkg.sv =====
// package for the hid report to key event converter
// holds widths, event codes and the code tables
package hrke_pkg;
   localparam int KeySlots = 6;
   localparam int KeyMax = 16;
   localparam logic [7:0] ShiftMask = 8'h22;
   localparam logic [7:0] ReleaseBit = 8'h80;
   localparam logic KindPress = 1'b0;
   localparam logic KindRelease = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] usage;
      logic [6:0] ascii;
      logic [7:0] ps2;
      logic       last;
   } event_type;

   function automatic logic [7:0] ps2_of(input logic [7:0] u);
      logic [7:0] r;
      r = 8'h00;
      if (u >= 8'h68) begin
         r = u - 8'd4;
      end else if (u >= 8'h04 && u <= 8'h1d) begin
         case (u)
            8'h04: r = 8'h1e; 8'h05: r = 8'h30; 8'h06: r = 8'h2e; 8'h07: r = 8'h20;
            8'h08: r = 8'h12; 8'h09: r = 8'h21; 8'h0a: r = 8'h22; 8'h0b: r = 8'h23;
            8'h0c: r = 8'h17; 8'h0d: r = 8'h24; 8'h0e: r = 8'h25; 8'h0f: r = 8'h26;
            8'h10: r = 8'h32; 8'h11: r = 8'h31; 8'h12: r = 8'h18; 8'h13: r = 8'h19;
            8'h14: r = 8'h10; 8'h15: r = 8'h13; 8'h16: r = 8'h1f; 8'h17: r = 8'h14;
            8'h18: r = 8'h16; 8'h19: r = 8'h2f; 8'h1a: r = 8'h11; 8'h1b: r = 8'h2d;
            8'h1c: r = 8'h2c; 8'h1d: r = 8'h15;
            default: r = 8'h00;
         endcase
      end else begin
         case (u)
            8'h1e: r = 8'h02; 8'h1f: r = 8'h03; 8'h20: r = 8'h04; 8'h21: r = 8'h05;
            8'h22: r = 8'h06; 8'h23: r = 8'h07; 8'h24: r = 8'h08; 8'h25: r = 8'h09;
            8'h26: r = 8'h0a; 8'h27: r = 8'h0b; 8'h28: r = 8'h1c; 8'h29: r = 8'h01;
            8'h2a: r = 8'h0e; 8'h2b: r = 8'h0f; 8'h2c: r = 8'h39; 8'h2d: r = 8'h0c;
            8'h2e: r = 8'h0d; 8'h2f: r = 8'h1a; 8'h30: r = 8'h1b; 8'h31: r = 8'h2b;
            8'h33: r = 8'h27; 8'h34: r = 8'h28; 8'h35: r = 8'h29; 8'h36: r = 8'h33;
            8'h37: r = 8'h34; 8'h38: r = 8'h35; 8'h39: r = 8'h3a; 8'h3a: r = 8'h3b;
            8'h3b: r = 8'h3c; 8'h3c: r = 8'h3d; 8'h3d: r = 8'h3e; 8'h3e: r = 8'h3f;
            8'h3f: r = 8'h40; 8'h40: r = 8'h41; 8'h41: r = 8'h42; 8'h42: r = 8'h43;
            8'h43: r = 8'h44; 8'h44: r = 8'h45; 8'h45: r = 8'h46; 8'h46: r = 8'h54;
            8'h47: r = 8'h47; 8'h48: r = 8'h48; 8'h49: r = 8'hd2; 8'h4a: r = 8'hc7;
            8'h4b: r = 8'hc9; 8'h4c: r = 8'hd3; 8'h4d: r = 8'hcf; 8'h4e: r = 8'h4b;
            8'h4f: r = 8'h50; 8'h50: r = 8'h4d; 8'h51: r = 8'h48; 8'h53: r = 8'h45;
            8'h54: r = 8'h54; 8'h55: r = 8'h37; 8'h56: r = 8'h4a; 8'h57: r = 8'h4e;
            8'h58: r = 8'h58; 8'h59: r = 8'h4f; 8'h5a: r = 8'h50; 8'h5b: r = 8'h51;
            8'h5c: r = 8'h4b; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h4d; 8'h5f: r = 8'h47;
            8'h60: r = 8'h48; 8'h61: r = 8'h49; 8'h62: r = 8'h52; 8'h63: r = 8'h53;
            8'h64: r = 8'h56;
            default: r = 8'h00;
         endcase
      end
      return r;
   endfunction

   function automatic logic [6:0] ascii_of(input logic [7:0] u, input logic sh);
      logic [6:0] r;
      r = 7'h00;
      if (u >= 8'h04 && u <= 8'h1d) begin
         r = (sh ? 7'h41 : 7'h61) + 7'(u - 8'h04);
      end else begin
         case (u)
            8'h1e: r = sh ? 7'h21 : 7'h31; 8'h1f: r = sh ? 7'h40 : 7'h32;
            8'h20: r = sh ? 7'h23 : 7'h33; 8'h21: r = sh ? 7'h24 : 7'h34;
            8'h22: r = sh ? 7'h25 : 7'h35; 8'h23: r = sh ? 7'h5e : 7'h36;
            8'h24: r = sh ? 7'h26 : 7'h37; 8'h25: r = sh ? 7'h2a : 7'h38;
            8'h26: r = sh ? 7'h28 : 7'h39; 8'h27: r = sh ? 7'h29 : 7'h30;
            8'h28: r = 7'h0a; 8'h29: r = 7'h1b; 8'h2a: r = 7'h08; 8'h2b: r = 7'h09;
            8'h2c: r = 7'h20;
            8'h2d: r = sh ? 7'h5f : 7'h2d; 8'h2e: r = sh ? 7'h2b : 7'h3d;
            8'h2f: r = sh ? 7'h7b : 7'h5b; 8'h30: r = sh ? 7'h7d : 7'h5d;
            8'h31: r = sh ? 7'h7c : 7'h5c;
            8'h33: r = sh ? 7'h3a : 7'h3b; 8'h34: r = sh ? 7'h22 : 7'h27;
            8'h35: r = sh ? 7'h7e : 7'h60; 8'h36: r = sh ? 7'h3c : 7'h2c;
            8'h37: r = sh ? 7'h3e : 7'h2e; 8'h38: r = sh ? 7'h3f : 7'h2f;
            default: r = 7'h00;
         endcase
      end
      return r;
   endfunction
endpackage

// ===== hw/rtl/hrke_if.sv =====
// valid/ready channel interface carrying a payload word
// depends on nothing
interface hrke_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hrke_front.sv =====
// front end: takes a report, diffs it against the stored one and queues it
// depends on hrke_pkg
module hrke_front #(
   parameter int KEY_SLOTS = hrke_pkg::KeySlots
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [7:0]              in_mods,
   input  logic [KEY_SLOTS*8-1:0]  in_keys,
   output logic                    q_valid,
   input  logic                    q_pop,
   output logic                    q_shift,
   output logic [KEY_SLOTS*8-1:0]  q_old,
   output logic [KEY_SLOTS*8-1:0]  q_new,
   output logic [KEY_SLOTS-1:0]    q_rel,
   output logic [KEY_SLOTS-1:0]    q_prs
);
   logic [KEY_SLOTS*8-1:0] prev_ff;
   logic                   full_ff;
   logic                   shift_ff;
   logic [KEY_SLOTS*8-1:0] old_ff, new_ff;
   logic [KEY_SLOTS-1:0]   rel_ff, prs_ff, rel_in, prs_in;
   logic                   take;

   assign in_ready = !full_ff || q_pop;
   assign take = in_valid && in_ready;

   // per-slot membership test
   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         rel_in[i] = prev_ff[i*8 +: 8] != 8'h00;
         prs_in[i] = in_keys[i*8 +: 8] != 8'h00;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (in_keys[j*8 +: 8] == prev_ff[i*8 +: 8]) rel_in[i] = 1'b0;
            if (prev_ff[j*8 +: 8] == in_keys[i*8 +: 8]) prs_in[i] = 1'b0;
         end
      end
   end

   // one-entry queue and stored report
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         prev_ff <= '0;
      end else begin
         if (take) full_ff <= 1'b1;
         else if (q_pop) full_ff <= 1'b0;
         if (take) prev_ff <= in_keys;
      end
      if (take) begin
         shift_ff <= (in_mods & hrke_pkg::ShiftMask) != 8'h00;
         old_ff <= prev_ff;
         new_ff <= in_keys;
         rel_ff <= rel_in;
         prs_ff <= prs_in;
      end
   end

   assign q_valid = full_ff;
   assign q_shift = shift_ff;
   assign q_old = old_ff;
   assign q_new = new_ff;
   assign q_rel = rel_ff;
   assign q_prs = prs_ff;
endmodule

// ===== hw/rtl/hrke_back.sv =====
// back end: walks release then press slots, at most one event word per slot step; a held word not taken stalls the walk
// depends on hrke_pkg
module hrke_back #(
   parameter int KEY_SLOTS = hrke_pkg::KeySlots
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  logic                    q_shift,
   input  logic [KEY_SLOTS*8-1:0]  q_old,
   input  logic [KEY_SLOTS*8-1:0]  q_new,
   input  logic [KEY_SLOTS-1:0]    q_rel,
   input  logic [KEY_SLOTS-1:0]    q_prs,
   output logic                    out_valid,
   input  logic                    out_ready,
   output hrke_pkg::event_type     out_data
);
   localparam int StepW = $clog2(2*KEY_SLOTS + 1);
   localparam int SlotW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   logic [StepW-1:0]     step_ff;
   logic                 held_ff;
   hrke_pkg::event_type  held_data_ff;
   logic [2*KEY_SLOTS-1:0] keep;
   logic                 cur_keep, cur_rel, more, advance, is_end;
   logic [SlotW-1:0]     slot;
   logic [7:0]           usage, code;
   logic [6:0]           ch;

   // mask of steps that yield an event
   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         keep[i] = q_rel[i] && (hrke_pkg::ps2_of(q_old[i*8 +: 8]) != 8'h00);
         keep[KEY_SLOTS+i] = q_prs[i] &&
            ((hrke_pkg::ps2_of(q_new[i*8 +: 8]) != 8'h00) ||
             (hrke_pkg::ascii_of(q_new[i*8 +: 8], q_shift) != 7'h00));
      end
   end

   always_comb begin
      is_end = step_ff == StepW'(2*KEY_SLOTS - 1);
      cur_keep = keep[step_ff[$clog2(2*KEY_SLOTS)-1:0]];
      cur_rel = step_ff < StepW'(KEY_SLOTS);
      slot = cur_rel ? SlotW'(step_ff) : SlotW'(step_ff - StepW'(KEY_SLOTS));
      usage = cur_rel ? q_old[slot*8 +: 8] : q_new[slot*8 +: 8];
      code = hrke_pkg::ps2_of(usage);
      ch = cur_rel ? 7'h00 : hrke_pkg::ascii_of(usage, q_shift);
      more = 1'b0;
      for (int k = 0; k < 2*KEY_SLOTS; k++)
         if (StepW'(k) > step_ff && keep[k]) more = 1'b1;
      advance = q_valid && (!held_ff || out_ready);
      q_pop = advance && is_end;
   end

   // step counter and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         held_ff <= 1'b0;
      end else begin
         if (advance && cur_keep) held_ff <= 1'b1;
         else if (out_ready) held_ff <= 1'b0;
         if (advance) begin
            step_ff <= is_end ? '0 : step_ff + 1'b1;
         end
      end
      if (advance && cur_keep) begin
         held_data_ff.kind <= cur_rel ? hrke_pkg::KindRelease : hrke_pkg::KindPress;
         held_data_ff.usage <= usage;
         held_data_ff.ascii <= ch;
         held_data_ff.ps2 <= cur_rel ? (code | hrke_pkg::ReleaseBit) : code;
         held_data_ff.last <= !more;
      end
   end

   assign out_valid = held_ff;
   assign out_data = held_data_ff;
endmodule

// ===== hw/rtl/hid_report_to_key_events.sv =====
// Converts a USB HID boot keyboard report into one event word per key
// released (first, old slot order) or pressed (then, new slot order), with
// PS/2 set-1 codes and ASCII; a key with no PS/2 code (and, on a press, no
// character) gets no word. The back end walks every slot step of a report,
// stalling while a held output word is not taken; the front end's one-entry
// queue holds the report being walked and takes the next report in the cycle the last step retires.
// Depends on hrke_pkg, hrke_front, hrke_back and assert_macros.svh.
`include "assert_macros.svh"
module hid_report_to_key_events #(
   parameter int KEY_SLOTS = hrke_pkg::KeySlots
) (
   input  logic clock,
   input  logic reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_modifiers,
   input  logic [KEY_SLOTS*8-1:0] req_key_slots,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_event_kind,
   output logic [7:0]             rsp_usage_code,
   output logic [6:0]             rsp_ascii_char,
   output logic [7:0]             rsp_ps2_code,
   output logic                   rsp_last_event
);
   logic                   q_valid, q_pop, q_shift;
   logic [KEY_SLOTS*8-1:0] q_old, q_new;
   logic [KEY_SLOTS-1:0]   q_rel, q_prs;
   hrke_pkg::event_type    ev;

   hrke_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready),
      .in_mods(req_modifiers), .in_keys(req_key_slots),
      .q_valid, .q_pop, .q_shift, .q_old, .q_new, .q_rel, .q_prs);

   hrke_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_shift, .q_old, .q_new, .q_rel, .q_prs,
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(ev));

   assign rsp_event_kind = ev.kind;
   assign rsp_usage_code = ev.usage;
   assign rsp_ascii_char = ev.ascii;
   assign rsp_ps2_code = ev.ps2;
   assign rsp_last_event = ev.last;

   // a release always carries the release bit and no character
   `ASSERT_ALWAYS(a_rel_form, clock, reset,
      !(rsp_valid && rsp_event_kind) || (rsp_ps2_code[7] && rsp_ascii_char == 7'h00))
   // the queue can pop only while holding a report
   `ASSERT_ALWAYS(a_pop_full, clock, reset, !q_pop || q_valid)
   // a stalled event word holds
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(ev))
endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for hid_report_to_key_events
// depends on hid_report_to_key_events, hrke_pkg and hrke_if from the rtl; a local predictor builds the events
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 600000;
   localparam int DrainCycles = 40;
   localparam int LongHold = 400;

   typedef struct packed {
      logic [7:0]      modifiers;
      logic [5:0][7:0] slots;
   } report_type;

   // key usage to ps/2 set-1 code, beyond the table the code is usage minus 4
   localparam logic [7:0] PS2_CODES [0:103] = '{
      8'h00,8'h00,8'h00,8'h00,8'h1e,8'h30,8'h2e,8'h20,
      8'h12,8'h21,8'h22,8'h23,8'h17,8'h24,8'h25,8'h26,
      8'h32,8'h31,8'h18,8'h19,8'h10,8'h13,8'h1f,8'h14,
      8'h16,8'h2f,8'h11,8'h2d,8'h2c,8'h15,8'h02,8'h03,
      8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,8'h0b,
      8'h1c,8'h01,8'h0e,8'h0f,8'h39,8'h0c,8'h0d,8'h1a,
      8'h1b,8'h2b,8'h00,8'h27,8'h28,8'h29,8'h33,8'h34,
      8'h35,8'h3a,8'h3b,8'h3c,8'h3d,8'h3e,8'h3f,8'h40,
      8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h54,8'h47,
      8'h48,8'hd2,8'hc7,8'hc9,8'hd3,8'hcf,8'h4b,8'h50,
      8'h4d,8'h48,8'h00,8'h45,8'h54,8'h37,8'h4a,8'h4e,
      8'h58,8'h4f,8'h50,8'h51,8'h4b,8'h4c,8'h4d,8'h47,
      8'h48,8'h49,8'h52,8'h53,8'h56,8'h00,8'h00,8'h00};

   // characters for usages 0x1e..0x38, plain and shifted
   localparam logic [6:0] CHAR_PLAIN [0:26] = '{
      7'h31,7'h32,7'h33,7'h34,7'h35,7'h36,7'h37,7'h38,7'h39,7'h30,
      7'h0a,7'h1b,7'h08,7'h09,7'h20,7'h2d,7'h3d,7'h5b,7'h5d,7'h5c,
      7'h00,7'h3b,7'h27,7'h60,7'h2c,7'h2e,7'h2f};
   localparam logic [6:0] CHAR_SHIFT [0:26] = '{
      7'h21,7'h40,7'h23,7'h24,7'h25,7'h5e,7'h26,7'h2a,7'h28,7'h29,
      7'h0a,7'h1b,7'h08,7'h09,7'h20,7'h5f,7'h2b,7'h7b,7'h7d,7'h7c,
      7'h00,7'h3a,7'h22,7'h7e,7'h3c,7'h3e,7'h3f};

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrke_if #(.payload_type(report_type))          report_ch ();
   hrke_if #(.payload_type(hrke_pkg::event_type)) event_ch ();

   hid_report_to_key_events u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (report_ch.valid),
      .req_ready      (report_ch.ready),
      .req_modifiers  (report_ch.data.modifiers),
      .req_key_slots  (report_ch.data.slots),
      .rsp_valid      (event_ch.valid),
      .rsp_ready      (event_ch.ready),
      .rsp_event_kind (event_ch.data.kind),
      .rsp_usage_code (event_ch.data.usage),
      .rsp_ascii_char (event_ch.data.ascii),
      .rsp_ps2_code   (event_ch.data.ps2),
      .rsp_last_event (event_ch.data.last)
   );

   report_type          pending_reports[$];
   hrke_pkg::event_type expected_events[$];
   logic [7:0] held_keys [0:5];
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_request = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned reports_taken = 0;
   int unsigned events_checked = 0;
   int unsigned releases_seen = 0;
   int unsigned errors = 0;
   int unsigned cycle_count = 0;

   function automatic logic [7:0] code_of(input logic [7:0] u);
      return (u < 8'h68) ? PS2_CODES[u] : u - 8'd4;
   endfunction

   function automatic logic [6:0] char_of(input logic [7:0] u, input logic sh);
      if (u >= 8'h04 && u <= 8'h1d) return (sh ? 7'h41 : 7'h61) + 7'(u - 8'h04);
      if (u >= 8'h1e && u <= 8'h38) return sh ? CHAR_SHIFT[u - 8'h1e] : CHAR_PLAIN[u - 8'h1e];
      return 7'h00;
   endfunction

   // releases in old slot order, then presses in new slot order, then store
   task automatic predict_key_events(input report_type r);
      hrke_pkg::event_type ev;
      logic      sh;
      logic      found;
      int        n;
      sh = (r.modifiers & hrke_pkg::ShiftMask) != 0;
      n = 0;
      for (int i = 0; i < 6; i++) begin
         found = 1'b0;
         for (int j = 0; j < 6; j++) if (r.slots[j] == held_keys[i]) found = 1'b1;
         if (held_keys[i] != 0 && !found && code_of(held_keys[i]) != 0) begin
            ev = '{hrke_pkg::KindRelease, held_keys[i], 7'h00,
                   code_of(held_keys[i]) | hrke_pkg::ReleaseBit, 1'b0};
            expected_events.push_back(ev);
            n++;
         end
      end
      for (int i = 0; i < 6; i++) begin
         found = 1'b0;
         for (int j = 0; j < 6; j++) if (held_keys[j] == r.slots[i]) found = 1'b1;
         if (r.slots[i] != 0 && !found &&
             (code_of(r.slots[i]) != 0 || char_of(r.slots[i], sh) != 0)) begin
            ev = '{hrke_pkg::KindPress, r.slots[i], char_of(r.slots[i], sh),
                   code_of(r.slots[i]), 1'b0};
            expected_events.push_back(ev);
            n++;
         end
      end
      if (n > 0) expected_events[$].last = 1'b1;
      for (int i = 0; i < 6; i++) held_keys[i] = r.slots[i];
   endtask

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // report driver
   always @(posedge clock) begin
      if (reset) begin
         report_ch.valid <= 1'b0;
         report_ch.data <= '0;
      end else if (!report_ch.valid || report_ch.ready) begin
         if (pending_reports.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            report_ch.valid <= 1'b1;
            report_ch.data <= pending_reports.pop_front();
         end else begin
            report_ch.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= LongHold;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // event sink ready
   always @(posedge clock) begin
      if (reset) event_ch.ready <= 1'b0;
      else event_ch.ready <= (hold_left <= 1) && ($urandom_range(99) >= recv_stall_pct);
   end

   // accepted reports feed the predictor, accepted events are checked
   always @(posedge clock) begin
      if (!reset && report_ch.valid && report_ch.ready) begin
         predict_key_events(report_ch.data);
         reports_taken++;
      end
      if (!reset && event_ch.valid && event_ch.ready) begin
         if (expected_events.size() == 0) begin
            $error("unexpected word: kind=%0d usage=%h", event_ch.data.kind,
                   event_ch.data.usage);
            errors++;
         end else begin
            hrke_pkg::event_type want;
            want = expected_events.pop_front();
            if (want.kind != event_ch.data.kind) begin
               $error("event_kind: expected %0d, got %0d", want.kind, event_ch.data.kind);
               errors++;
            end
            if (want.usage != event_ch.data.usage) begin
               $error("usage_code: expected %h, got %h", want.usage, event_ch.data.usage);
               errors++;
            end
            if (want.ascii != event_ch.data.ascii) begin
               $error("ascii_char: expected %h, got %h", want.ascii, event_ch.data.ascii);
               errors++;
            end
            if (want.ps2 != event_ch.data.ps2) begin
               $error("ps2_code: expected %h, got %h", want.ps2, event_ch.data.ps2);
               errors++;
            end
            if (want.last != event_ch.data.last) begin
               $error("last_event: expected %0d, got %0d", want.last, event_ch.data.last);
               errors++;
            end
            if (want.kind == hrke_pkg::KindRelease) releases_seen++;
         end
         events_checked++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic report_type make_report(input logic [7:0] m, input logic [7:0] s0,
         input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] s3,
         input logic [7:0] s4, input logic [7:0] s5);
      report_type r;
      r.modifiers = m;
      r.slots = {s5, s4, s3, s2, s1, s0};
      return r;
   endfunction

   // next report of a plausible typing sequence, or noise
   function automatic report_type next_report(input report_type cur);
      report_type r;
      int unsigned pick;
      r = cur;
      if ($urandom_range(99) < 12) begin
         r = report_type'(56'({$urandom(), $urandom()}));
         return r;
      end
      r.modifiers = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom());
      for (int i = 0; i < 6; i++) begin
         pick = $urandom_range(99);
         if (pick < 20) r.slots[i] = 8'h00;
         else if (pick < 42) r.slots[i] = 8'($urandom_range(8'h04, 8'h70));
         else if (pick < 47) r.slots[i] = 8'($urandom());
      end
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reports.size() > 0 || report_ch.valid || expected_events.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // stimulus sequencing
   initial begin
      report_type r;
      for (int i = 0; i < 6; i++) held_keys[i] = 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, shift, codes above 0x7f, dropped keys, repeats
      pending_reports.push_back(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      pending_reports.push_back(make_report(8'h00, 8'h04, 8'h1d, 8'h1e, 8'h27, 8'h38, 8'h39));
      pending_reports.push_back(make_report(8'h02, 8'h04, 8'h1d, 8'h2d, 8'h31, 8'h35, 8'h38));
      pending_reports.push_back(make_report(8'h20, 8'h49, 8'h4a, 8'h4d, 8'h1f, 8'h23, 8'h34));
      pending_reports.push_back(make_report(8'hff, 8'hff, 8'hfe, 8'h80, 8'h68, 8'h67, 8'h32));
      pending_reports.push_back(make_report(8'hdd, 8'h32, 8'h01, 8'h02, 8'h03, 8'h65, 8'h66));
      pending_reports.push_back(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      pending_reports.push_back(make_report(8'h22, 8'h04, 8'h04, 8'h04, 8'h49, 8'h49, 8'h00));
      pending_reports.push_back(make_report(8'h22, 8'h04, 8'h04, 8'h04, 8'h49, 8'h49, 8'h00));
      pending_reports.push_back(make_report(8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00));
      pending_reports.push_back(make_report(8'h00, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h52));
      pending_reports.push_back(make_report(8'h00, 8'h52, 8'h2c, 8'h2b, 8'h2a, 8'h29, 8'h28));
      pending_reports.push_back(make_report(8'haa, 8'h55, 8'h8c, 8'h33, 8'h36, 8'h37, 8'h2e));
      pending_reports.push_back(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      wait_drained();

      // sender pause until every event has come, then a long receiver hold-off
      r = make_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
      pending_reports.push_back(r);
      wait_drained();
      hold_request++;
      for (int i = 0; i < 10; i++) begin
         r = next_report(r);
         pending_reports.push_back(r);
      end
      wait_drained();

      // random phases with different idling on either side
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            3: begin send_idle_pct = 24; recv_stall_pct = 24; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (int i = 0; i < 40; i++) begin
            r = next_report(r);
            pending_reports.push_back(r);
         end
         wait_drained();
      end

      $display("tb: %0d reports, %0d events checked (%0d releases), idle and stall mixes",
               reports_taken, events_checked, releases_seen);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
